// File: sv/cau_pkg.sv
// Shared types and constants for the complex arithmetic unit.
`default_nettype none

package cau_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  typedef enum logic [2:0] {
    ACT_ADD  = 3'd0,
    ACT_SUB  = 3'd1,
    ACT_TRE  = 3'd2,
    ACT_TIM  = 3'd3,
    ACT_CMUL = 3'd4,
    ACT_MAG  = 3'd5
  } action_t;

  typedef struct packed {
    logic [2:0]                  action;
    logic signed [WORD_BITS-1:0] a_re;
    logic signed [WORD_BITS-1:0] a_im;
    logic signed [WORD_BITS-1:0] b_re;
    logic signed [WORD_BITS-1:0] b_im;
  } in_req_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] res_re;
    logic signed [WORD_BITS-1:0] res_im;
    logic                        saturated;
  } out_req_t;

endpackage

`default_nettype wire

// File: sv/cau_isqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none

module cau_isqrt (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic [2*cau_pkg::WORD_BITS-1:0]   rad,
  output logic      [cau_pkg::WORD_BITS-1:0]     root
);

  localparam int W = cau_pkg::WORD_BITS;

  logic [2*W-1:0] rad_r  [W];
  logic [W+1:0]   rem_r  [W];
  logic [W-1:0]   root_r [W];

  for (genvar i = 0; i < W; i++) begin : g_stage
    logic [2*W-1:0] rad_in;
    logic [W+1:0]   rem_in;
    logic [W-1:0]   root_in;
    logic [W+3:0]   rem_sh;
    logic [W+3:0]   trial;
    logic           ge;

    if (i == 0) begin : g_first
      assign rad_in  = rad;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
    end

    // Bring down the next pair of radicand bits and try the next root bit.
    assign rem_sh = {rem_in, rad_in[2*W-1:2*W-2]};
    assign trial  = {2'b00, root_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[i]  <= rad_in << 2;
        rem_r[i]  <= ge ? (W+2)'(rem_sh - trial) : (W+2)'(rem_sh);
        root_r[i] <= {root_in[W-2:0], ge};
      end
    end
  end

  assign root = root_r[W-1];

endmodule

`default_nettype wire

// File: sv/complex_arith_unit.sv
// Top level of the complex arithmetic unit: stage pipeline and output register.
//
// Requests arrive on the in_ channel (in_valid, in_stall, in_data) and each one
// yields exactly one result on the out_ channel (out_valid, out_stall, out_data).
// A request is taken at a rising edge where in_valid is high and in_stall is low.
// The unit is fully pipelined: a new request can be taken in every cycle
// unless out_stall holds the pipeline. The square-root pipeline resolves
// one root bit per stage; all other actions are delayed to the same length so
// that results leave in request order.
// When the receiver holds out_stall while a result is waiting, the whole
// pipeline freezes and in_stall rises in the same cycle; nothing is lost or
// repeated, and throughput returns to one per cycle as soon as the stall clears.
// Reset (rst_n low, synchronous) clears every valid bit, so the pipeline comes
// up empty; payload registers are not reset.
`default_nettype none

module complex_arith_unit #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire cau_pkg::in_req_t   in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output cau_pkg::out_req_t       out_data
);

  localparam int W = cau_pkg::WORD_BITS;
  localparam int P = 2 * W;
  localparam int S = 2 * W + 1;
  localparam int D = W - 2;
  localparam logic [S-1:0] HALF = (S'(1) << FRAC_BITS) >> 1;
  localparam logic [W-1:0] MAXPOS = (W'(1) << (W - 1)) - W'(1);
  localparam logic [W-1:0] MINMAG = W'(1) << (W - 1);

  // The whole pipeline advances together unless a finished result is held.
  logic en;
  logic out_valid_r;
  cau_pkg::out_req_t out_data_r;

  assign en        = !out_valid_r || !out_stall;
  assign in_stall  = !en;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Stage 1: request register.
  logic              s1_valid_r;
  cau_pkg::in_req_t  s1_req_r;

  // Stage 2: products and exact sums.
  logic                s2_valid_r;
  logic [2:0]          s2_act_r;
  logic signed [P-1:0] s2_p0_r, s2_p1_r, s2_p2_r, s2_p3_r;
  logic signed [W:0]   s2_sre_r, s2_sim_r;

  logic signed [W-1:0] x0, y0, x1, y1, x2, y2, x3, y3;
  logic signed [W:0]   sre_nxt, sim_nxt;
  cau_pkg::action_t    act1;

  assign act1 = cau_pkg::action_t'(s1_req_r.action);

  always_comb begin
    x0 = '0; y0 = '0; x1 = '0; y1 = '0;
    x2 = '0; y2 = '0; x3 = '0; y3 = '0;
    sre_nxt = '0;
    sim_nxt = '0;
    unique case (act1)
      cau_pkg::ACT_ADD: begin
        sre_nxt = (W+1)'(s1_req_r.a_re) + (W+1)'(s1_req_r.b_re);
        sim_nxt = (W+1)'(s1_req_r.a_im) + (W+1)'(s1_req_r.b_im);
      end
      cau_pkg::ACT_SUB: begin
        sre_nxt = (W+1)'(s1_req_r.a_re) - (W+1)'(s1_req_r.b_re);
        sim_nxt = (W+1)'(s1_req_r.a_im) - (W+1)'(s1_req_r.b_im);
      end
      cau_pkg::ACT_TRE: begin
        x0 = s1_req_r.a_re; y0 = s1_req_r.b_re;
        x2 = s1_req_r.a_im; y2 = s1_req_r.b_re;
      end
      cau_pkg::ACT_TIM: begin
        x0 = s1_req_r.a_im; y0 = s1_req_r.b_re;
        x2 = s1_req_r.a_re; y2 = s1_req_r.b_re;
      end
      cau_pkg::ACT_CMUL: begin
        x0 = s1_req_r.a_re; y0 = s1_req_r.b_re;
        x1 = s1_req_r.a_im; y1 = s1_req_r.b_im;
        x2 = s1_req_r.a_re; y2 = s1_req_r.b_im;
        x3 = s1_req_r.a_im; y3 = s1_req_r.b_re;
      end
      cau_pkg::ACT_MAG: begin
        x0 = s1_req_r.a_re; y0 = s1_req_r.a_re;
        x1 = s1_req_r.a_im; y1 = s1_req_r.a_im;
      end
      default: begin
      end
    endcase
  end

  // Stage 3: combine products; the magnitude radicand also leaves here.
  logic                s3_valid_r;
  logic                s3_rnd_r;
  logic                s3_mag_r;
  logic signed [S-1:0] s3_re_r, s3_im_r;

  logic signed [S-1:0] re3_nxt, im3_nxt;
  logic                rnd3_nxt;
  cau_pkg::action_t    act2;

  assign act2 = cau_pkg::action_t'(s2_act_r);

  always_comb begin
    re3_nxt  = '0;
    im3_nxt  = '0;
    rnd3_nxt = 1'b1;
    unique case (act2)
      cau_pkg::ACT_ADD, cau_pkg::ACT_SUB: begin
        re3_nxt  = S'(s2_sre_r);
        im3_nxt  = S'(s2_sim_r);
        rnd3_nxt = 1'b0;
      end
      cau_pkg::ACT_TRE: begin
        re3_nxt = S'(s2_p0_r);
        im3_nxt = S'(s2_p2_r);
      end
      cau_pkg::ACT_TIM: begin
        re3_nxt = -S'(s2_p0_r);
        im3_nxt = S'(s2_p2_r);
      end
      cau_pkg::ACT_CMUL: begin
        re3_nxt = S'(s2_p0_r) - S'(s2_p1_r);
        im3_nxt = S'(s2_p2_r) + S'(s2_p3_r);
      end
      cau_pkg::ACT_MAG: begin
        re3_nxt = S'(s2_p0_r) + S'(s2_p1_r);
      end
      default: begin
      end
    endcase
  end

  // Stage 4: sign and magnitude, products rounded half away from zero.
  logic         s4_valid_r;
  logic         s4_mag_r;
  logic         s4_re_neg_r, s4_im_neg_r;
  logic [S-1:0] s4_re_mag_r, s4_im_mag_r;

  logic         re_neg, im_neg;
  logic [S-1:0] re_abs, im_abs, re_rnd, im_rnd;

  assign re_neg = s3_re_r[S-1];
  assign im_neg = s3_im_r[S-1];
  assign re_abs = re_neg ? S'(-s3_re_r) : S'(s3_re_r);
  assign im_abs = im_neg ? S'(-s3_im_r) : S'(s3_im_r);
  assign re_rnd = s3_rnd_r ? ((re_abs + HALF) >> FRAC_BITS) : re_abs;
  assign im_rnd = s3_rnd_r ? ((im_abs + HALF) >> FRAC_BITS) : im_abs;

  // Stage 5: clip each part to the word range.
  logic         s5_valid_r;
  logic         s5_mag_r;
  logic [W-1:0] s5_re_r, s5_im_r;
  logic         s5_sat_r;

  logic [W-1:0] re_lim, im_lim, re_clip, im_clip;
  logic         re_over, im_over;

  assign re_lim  = s4_re_neg_r ? MINMAG : MAXPOS;
  assign im_lim  = s4_im_neg_r ? MINMAG : MAXPOS;
  assign re_over = s4_re_mag_r > S'(re_lim);
  assign im_over = s4_im_mag_r > S'(im_lim);
  assign re_clip = re_over ? re_lim : s4_re_mag_r[W-1:0];
  assign im_clip = im_over ? im_lim : s4_im_mag_r[W-1:0];

  // Delay line that keeps the other actions in step with the square root.
  logic         dl_valid_r [D];
  logic         dl_mag_r   [D];
  logic [W-1:0] dl_re_r    [D];
  logic [W-1:0] dl_im_r    [D];
  logic         dl_sat_r   [D];

  logic [W-1:0] root;

  cau_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .rad  (s3_re_r[P-1:0]),
    .root (root)
  );

  // Final merge: magnitude results take the root, clipped to the positive bound.
  cau_pkg::out_req_t out_nxt;

  always_comb begin
    out_nxt = '0;
    if (dl_mag_r[D-1]) begin
      out_nxt.res_re    = root[W-1] ? MAXPOS : root;
      out_nxt.res_im    = '0;
      out_nxt.saturated = root[W-1];
    end else begin
      out_nxt.res_re    = dl_re_r[D-1];
      out_nxt.res_im    = dl_im_r[D-1];
      out_nxt.saturated = dl_sat_r[D-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      s5_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < D; i++) begin
        dl_valid_r[i] <= 1'b0;
      end
    end else if (en) begin
      s1_valid_r    <= in_valid;
      s2_valid_r    <= s1_valid_r;
      s3_valid_r    <= s2_valid_r;
      s4_valid_r    <= s3_valid_r;
      s5_valid_r    <= s4_valid_r;
      dl_valid_r[0] <= s5_valid_r;
      for (int i = 1; i < D; i++) begin
        dl_valid_r[i] <= dl_valid_r[i-1];
      end
      out_valid_r <= dl_valid_r[D-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_req_r <= in_data;

      s2_act_r <= s1_req_r.action;
      s2_p0_r  <= P'(x0) * P'(y0);
      s2_p1_r  <= P'(x1) * P'(y1);
      s2_p2_r  <= P'(x2) * P'(y2);
      s2_p3_r  <= P'(x3) * P'(y3);
      s2_sre_r <= sre_nxt;
      s2_sim_r <= sim_nxt;

      s3_re_r  <= re3_nxt;
      s3_im_r  <= im3_nxt;
      s3_rnd_r <= rnd3_nxt;
      s3_mag_r <= (act2 == cau_pkg::ACT_MAG);

      s4_mag_r    <= s3_mag_r;
      s4_re_neg_r <= re_neg;
      s4_im_neg_r <= im_neg;
      s4_re_mag_r <= re_rnd;
      s4_im_mag_r <= im_rnd;

      s5_mag_r <= s4_mag_r;
      s5_re_r  <= s4_re_neg_r ? W'(-re_clip) : re_clip;
      s5_im_r  <= s4_im_neg_r ? W'(-im_clip) : im_clip;
      s5_sat_r <= re_over || im_over;

      dl_mag_r[0] <= s5_mag_r;
      dl_re_r[0]  <= s5_re_r;
      dl_im_r[0]  <= s5_im_r;
      dl_sat_r[0] <= s5_sat_r;
      for (int i = 1; i < D; i++) begin
        dl_mag_r[i] <= dl_mag_r[i-1];
        dl_re_r[i]  <= dl_re_r[i-1];
        dl_im_r[i]  <= dl_im_r[i-1];
        dl_sat_r[i] <= dl_sat_r[i-1];
      end

      out_data_r <= out_nxt;
    end
  end

endmodule

`default_nettype wire
